@@ rtl/pmsc_pkg.sv @@
// pmsc_pkg: shared types and constants for the priority message scheduler
// no dependencies
`timescale 1ns / 1ps
package pmsc_pkg;

  localparam int unsigned IdW = 16;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CntW = 32;
  localparam logic [TimeW-1:0] MinPlayMs = 16'd100;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_ACCEPT = 2'd0,
    EV_REJECT = 2'd1,
    EV_FINISH = 2'd2,
    EV_START  = 2'd3
  } ev_e;

  localparam logic CfgMaxQueued = 1'b0;
  localparam logic CfgGap = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic signed [15:0] prio;
    logic [TimeW-1:0] dur;
    logic [TimeW-1:0] cd;
  } msg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic cd_clr;     // reset cooldown scan pointer
    logic cd_scan;    // one cooldown step (lookup or decrement or store search)
    logic q_clr;      // reset queue scan pointer
    logic q_scan;     // one queue step (min search or insertion search)
    logic do_enq;     // commit insertion and clear the eviction flag
    logic do_start;   // pop head and start playing
    logic do_tick;    // update play / gap timers
    logic do_clear;   // clear queue and playback
    logic cd_write;   // write cooldown slot
    logic drop_inc;
    logic emit;       // load output register
    logic [1:0] emit_ev;
    logic emit_cur;   // emit current message rather than input
    logic emit_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic cd_done;
    logic q_done;
    logic cooling;
    logic id_zero;
    logic full;
    logic q_empty;
    logic evict_ok;
    logic can_start;
    logic finishing;
    logic playing;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/pmsc_ctrl.sv @@
// pmsc_ctrl: sequencing state machine for the scheduler
// depends on pmsc_pkg
`timescale 1ns / 1ps
module pmsc_ctrl import pmsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_COOL, S_DECIDE, S_QSCAN, S_EVICT, S_INS,
    S_EMIT1, S_TICKCD, S_TICKT, S_START, S_SCD, S_WAIT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctl_o = '0;
    case (state_q)
      S_IDLE:     ctl_o.load = in_valid_i;
      S_DISPATCH: begin
        ctl_o.cd_clr = 1'b1;
        ctl_o.q_clr = 1'b1;
        ctl_o.do_clear = (sts_i.cmd == CMD_CLEAR);
      end
      S_COOL:     ctl_o.cd_scan = 1'b1;
      S_DECIDE: begin
        if (!sts_i.out_busy && (sts_i.id_zero || sts_i.cooling ||
            (sts_i.full && sts_i.q_empty))) begin
          ctl_o.drop_inc = 1'b1;
          ctl_o.emit = 1'b1;
          ctl_o.emit_ev = EV_REJECT;
          ctl_o.emit_last = 1'b1;
        end
      end
      S_QSCAN:    ctl_o.q_scan = 1'b1;
      S_EVICT: begin
        if (!sts_i.out_busy) begin
          ctl_o.drop_inc = 1'b1;
          if (!sts_i.evict_ok) begin
            ctl_o.emit = 1'b1;
            ctl_o.emit_ev = EV_REJECT;
            ctl_o.emit_last = 1'b1;
          end
        end
      end
      S_INS: begin
        ctl_o.q_scan = 1'b1;
        if (sts_i.q_done) ctl_o.do_enq = 1'b1;
      end
      S_EMIT1: begin
        if (!sts_i.out_busy) begin
          ctl_o.emit = 1'b1;
          ctl_o.emit_ev = EV_ACCEPT;
          ctl_o.emit_last = !sts_i.can_start;
          ctl_o.cd_clr = 1'b1;
        end
      end
      S_TICKCD:   ctl_o.cd_scan = 1'b1;
      S_TICKT: begin
        if (!sts_i.out_busy) begin
          ctl_o.do_tick = 1'b1;
          ctl_o.cd_clr = 1'b1;
          if (sts_i.finishing) begin
            ctl_o.emit = 1'b1;
            ctl_o.emit_ev = EV_FINISH;
            ctl_o.emit_cur = 1'b1;
            ctl_o.emit_last = !sts_i.can_start;
          end
        end
      end
      S_SCD:      ctl_o.cd_scan = 1'b1;
      S_START: begin
        if (!sts_i.out_busy) begin
          ctl_o.cd_write = 1'b1;
          ctl_o.do_start = 1'b1;
          ctl_o.emit = 1'b1;
          ctl_o.emit_ev = EV_START;
          ctl_o.emit_cur = 1'b1;
          ctl_o.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISPATCH;
        S_DISPATCH: begin
          case (sts_i.cmd)
            CMD_ENQ:  state_q <= S_COOL;
            CMD_TICK: state_q <= S_TICKCD;
            default:  state_q <= S_WAIT;
          endcase
        end
        S_COOL: if (sts_i.cd_done) state_q <= S_DECIDE;
        S_DECIDE: begin
          if (sts_i.id_zero || sts_i.cooling || (sts_i.full && sts_i.q_empty)) begin
            if (!sts_i.out_busy) state_q <= S_WAIT;
          end else if (sts_i.full) begin
            state_q <= S_QSCAN;
          end else begin
            state_q <= S_INS;
          end
        end
        S_QSCAN: if (sts_i.q_done) state_q <= S_EVICT;
        S_EVICT: if (!sts_i.out_busy) state_q <= sts_i.evict_ok ? S_INS : S_WAIT;
        S_INS: if (sts_i.q_done) state_q <= S_EMIT1;
        S_EMIT1: if (!sts_i.out_busy) state_q <= sts_i.can_start ? S_SCD : S_WAIT;
        S_TICKCD: if (sts_i.cd_done) state_q <= S_TICKT;
        S_TICKT: if (!sts_i.out_busy) state_q <= sts_i.can_start ? S_SCD : S_WAIT;
        S_SCD: if (sts_i.cd_done) state_q <= S_START;
        S_START: if (!sts_i.out_busy) state_q <= S_WAIT;
        S_WAIT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> !sts_i.out_busy)
    else $error("emit while output register full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.do_start |-> !sts_i.q_empty)
    else $error("start with empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> state_q == S_DISPATCH)
    else $error("load did not dispatch");

endmodule

@@ rtl/pmsc_dp.sv @@
// pmsc_dp: queue, cooldown table, timers, counters and output register
// depends on pmsc_pkg
`timescale 1ns / 1ps
module pmsc_dp import pmsc_pkg::*; #(
  parameter int unsigned QueueDepth = 8,
  parameter int unsigned CooldownEntries = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  msg_t        msg_i,
  input  logic [TimeW-1:0] elapsed_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  ev_o,
  output msg_t        ev_msg_o,
  output logic [CntW-1:0] dropped_o,
  output logic [CntW-1:0] played_o,
  output logic        last_o
);

  localparam int unsigned QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(QueueDepth + 1);
  localparam int unsigned CW = (CooldownEntries > 1) ? $clog2(CooldownEntries) : 1;
  localparam int unsigned CCW = $clog2(CooldownEntries + 1);

  // queue entries: flop array, shifted in place one entry at a time on insertion and eviction
  msg_t q_mem [QueueDepth];
  logic [QCW-1:0] q_cnt_q;
  logic [QCW-1:0] qp_q;      // scan pointer (counts down on insertion)
  logic [QW-1:0]  low_q;
  logic signed [15:0] lowp_q;
  logic evict_ok_q;
  logic ins_sh_q;            // insertion is shifting entries

  logic [IdW-1:0]   cd_key [CooldownEntries];
  logic [TimeW-1:0] cd_left [CooldownEntries];
  logic [CCW-1:0] cp_q;
  logic cooling_q;
  logic own_f_q, exp_f_q;
  logic [CW-1:0] own_q, exp_q, min_q;
  logic [TimeW-1:0] minv_q;

  cmd_e cmd_q;
  msg_t m_q, cur_q;
  logic [TimeW-1:0] el_q;
  logic [3:0] maxq_q;
  logic [TimeW-1:0] gapc_q;
  logic playing_q;
  logic [TimeW-1:0] play_q, gap_q;
  logic [CntW-1:0] drop_q, play_cnt_q;
  logic start_sh_q;
  logic [QCW-1:0] sp_q;

  // scan for a start is marked when entering the start path
  logic start_pending_scan;
  logic scd_q;

  logic [QCW-1:0] limit;
  assign limit = ({28'd0, maxq_q} > QueueDepth) ? QCW'(QueueDepth) : QCW'(maxq_q);

  logic finishing;
  assign finishing = playing_q && (el_q >= play_q);

  // start is possible once timers have settled (start decision uses updated values)
  logic can_start_enq, can_start_tick;
  assign can_start_enq = !playing_q && (gap_q == '0);
  assign can_start_tick = finishing ? (gapc_q == '0 && q_cnt_q != '0) :
    (!playing_q && (gap_q <= el_q) && q_cnt_q != '0);

  assign sts_o.cmd = cmd_q;
  assign sts_o.cd_done = (cp_q == CCW'(CooldownEntries));
  assign sts_o.q_done = (ins_sh_q || start_sh_q) ? 1'b0 : (qp_q == '1);
  assign sts_o.cooling = cooling_q;
  assign sts_o.id_zero = (m_q.id == '0);
  assign sts_o.full = (q_cnt_q >= limit);
  assign sts_o.q_empty = (q_cnt_q == '0);
  assign sts_o.evict_ok = evict_ok_q;
  assign sts_o.can_start = (cmd_q == CMD_TICK) ? can_start_tick :
    (can_start_enq && !start_sh_q);
  assign sts_o.finishing = finishing;
  assign sts_o.playing = playing_q;
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

  logic [CW-1:0] ci;
  assign ci = cp_q[CW-1:0];
  logic [QW-1:0] qi;
  assign qi = qp_q[QW-1:0];

  // cooldown table: one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CooldownEntries; i++) begin
        cd_key[i] <= '0;
        cd_left[i] <= '0;
      end
      cp_q <= '0;
      cooling_q <= 1'b0;
      own_f_q <= 1'b0;
      exp_f_q <= 1'b0;
      own_q <= '0;
      exp_q <= '0;
      min_q <= '0;
      minv_q <= '0;
    end else begin
      if (ctl_i.cd_clr) begin
        cp_q <= '0;
        cooling_q <= 1'b0;
        own_f_q <= 1'b0;
        exp_f_q <= 1'b0;
        min_q <= '0;
        minv_q <= '1;
      end else if (ctl_i.cd_scan && cp_q != CCW'(CooldownEntries)) begin
        cp_q <= cp_q + 1'b1;
        if (cmd_q == CMD_TICK && !start_pending_scan) begin
          cd_left[ci] <= (cd_left[ci] > el_q) ? cd_left[ci] - el_q : '0;
        end else if (start_pending_scan) begin
          if (cd_key[ci] == q_mem[0].id && !own_f_q) begin
            own_f_q <= 1'b1;
            own_q <= ci;
          end
          if (cd_left[ci] == '0 && !exp_f_q) begin
            exp_f_q <= 1'b1;
            exp_q <= ci;
          end
          if (cp_q == '0 || cd_left[ci] < minv_q) begin
            min_q <= ci;
            minv_q <= cd_left[ci];
          end
        end else begin
          if (cd_key[ci] == m_q.id && cd_left[ci] != '0) cooling_q <= 1'b1;
        end
      end
      if (ctl_i.cd_write) begin
        cd_key[own_f_q ? own_q : (exp_f_q ? exp_q : min_q)] <= q_mem[0].id;
        cd_left[own_f_q ? own_q : (exp_f_q ? exp_q : min_q)] <= q_mem[0].cd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scd_q <= 1'b0;
    else if (ctl_i.load || ctl_i.cd_write) scd_q <= 1'b0;
    else if (ctl_i.emit && ctl_i.emit_ev != EV_START && !ctl_i.emit_last) scd_q <= 1'b1;
    else if (ctl_i.do_tick && !finishing && can_start_tick) scd_q <= 1'b1;
  end
  assign start_pending_scan = scd_q;

  // queue, timers, counters, input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
      qp_q <= '0;
      low_q <= '0;
      lowp_q <= '0;
      evict_ok_q <= 1'b0;
      ins_sh_q <= 1'b0;
      cmd_q <= CMD_NOP;
      maxq_q <= 4'd8;
      gapc_q <= '0;
      playing_q <= 1'b0;
      play_q <= '0;
      gap_q <= '0;
      cur_q <= '0;
      drop_q <= '0;
      play_cnt_q <= '0;
      start_sh_q <= 1'b0;
      sp_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgMaxQueued) maxq_q <= cfg_data_i[3:0];
      if (cfg_we_i && cfg_idx_i == CfgGap) gapc_q <= cfg_data_i;
      if (ctl_i.load) begin
        cmd_q <= cmd_e'(command_i);
        m_q <= msg_i;
        el_q <= elapsed_i;
      end
      if (ctl_i.drop_inc) drop_q <= drop_q + 1'b1;
      if (ctl_i.do_clear) begin
        q_cnt_q <= '0;
        playing_q <= 1'b0;
        play_q <= '0;
        gap_q <= '0;
        cur_q <= '0;
      end
      if (ctl_i.q_clr) begin
        qp_q <= '0;
        low_q <= '0;
        lowp_q <= '0;
        ins_sh_q <= 1'b0;
      end
      // min search (full queue) or insertion shift, held while an eviction shifts
      if (ctl_i.q_scan && !ctl_i.do_enq && !start_sh_q) begin
        if (!sts_o.full || evict_ok_q || ins_sh_q) begin
          // insertion: walk from the tail, one shift per cycle
          if (!ins_sh_q) begin
            ins_sh_q <= 1'b1;
            qp_q <= q_cnt_q;
          end else if (qp_q != '0 && q_mem[QW'(qp_q - 1'b1)].prio < m_q.prio) begin
            q_mem[QW'(qp_q)] <= q_mem[QW'(qp_q - 1'b1)];
            qp_q <= qp_q - 1'b1;
          end else begin
            ins_sh_q <= 1'b0;
            sp_q <= qp_q;
            qp_q <= '1;
          end
        end else begin
          if (qp_q < q_cnt_q) begin
            if (qp_q == '0 || q_mem[qi].prio < lowp_q) begin
              low_q <= qi;
              lowp_q <= q_mem[qi].prio;
            end
            qp_q <= qp_q + 1'b1;
          end else begin
            evict_ok_q <= (lowp_q < m_q.prio);
            sp_q <= QCW'(low_q);
            qp_q <= '1;
          end
        end
      end
      if (ctl_i.do_enq) begin
        q_mem[QW'(sp_q)] <= m_q;
        q_cnt_q <= q_cnt_q + 1'b1;
        evict_ok_q <= 1'b0;
      end
      if (ctl_i.drop_inc && evict_ok_q && !ctl_i.emit) begin
        // eviction: remove low entry, shifting the tail down one per cycle
        start_sh_q <= 1'b1;
        sp_q <= QCW'(low_q);
      end
      if (start_sh_q) begin
        if (sp_q + 1'b1 < q_cnt_q) begin
          q_mem[QW'(sp_q)] <= q_mem[QW'(sp_q + 1'b1)];
          sp_q <= sp_q + 1'b1;
        end else begin
          start_sh_q <= 1'b0;
          q_cnt_q <= q_cnt_q - 1'b1;
          qp_q <= '0;
          ins_sh_q <= 1'b0;
        end
      end
      if (ctl_i.do_tick) begin
        if (playing_q) begin
          if (finishing) begin
            play_q <= '0;
            playing_q <= 1'b0;
            gap_q <= gapc_q;
          end else begin
            play_q <= play_q - el_q;
          end
        end else if (gap_q != '0) begin
          gap_q <= (gap_q > el_q) ? gap_q - el_q : '0;
        end
      end
      if (ctl_i.do_start) begin
        cur_q <= q_mem[0];
        for (int i = 1; i < QueueDepth; i++) begin
          q_mem[i-1] <= q_mem[i];
        end
        q_cnt_q <= q_cnt_q - 1'b1;
        playing_q <= 1'b1;
        play_q <= (q_mem[0].dur < MinPlayMs) ? MinPlayMs : q_mem[0].dur;
        play_cnt_q <= play_cnt_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      ev_o <= ctl_i.emit_ev;
      last_o <= ctl_i.emit_last;
      if (ctl_i.emit_ev == EV_START) begin
        ev_msg_o <= q_mem[0];
        played_o <= play_cnt_q + 1'b1;
      end else begin
        ev_msg_o <= ctl_i.emit_cur ? cur_q : m_q;
        played_o <= play_cnt_q;
      end
      dropped_o <= ctl_i.drop_inc ? drop_q + 1'b1 : drop_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCW'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.do_enq |-> !start_sh_q)
    else $error("insert during eviction shift");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.do_start |=> playing_q)
    else $error("start did not set playing");

endmodule

@@ rtl/priority_message_scheduler_cooldown.sv @@
// priority_message_scheduler_cooldown: top level of the message scheduler
// depends on pmsc_pkg, pmsc_ctrl, pmsc_dp
// sequence for an item: dispatch, then a cooldown walk; an accept then walks the queue one
//   entry a cycle once any eviction shift is done (a full queue is first searched for its lowest
//   entry, which an eviction shifts out), a tick updates the timers after the walk, and a start
//   walks the cooldown table again before the head is popped
// throughput: one item at a time, taken after the last result; a stalled result holds the item
// reset: asynchronous, clears queue count, timers, counters and cooldown table
`timescale 1ns / 1ps
module priority_message_scheduler_cooldown import pmsc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned COOLDOWN_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] message_id_i,
  input  logic signed [15:0] message_priority_i,
  input  logic [15:0] duration_ms_i,
  input  logic [15:0] cooldown_ms_i,
  input  logic [15:0] elapsed_ms_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [15:0] event_id_o,
  output logic signed [15:0] event_priority_o,
  output logic [15:0] event_duration_o,
  output logic [15:0] event_cooldown_o,
  output logic [31:0] dropped_total_o,
  output logic [31:0] played_total_o,
  output logic last_o
);

  ctl_t ctl;
  sts_t sts;
  msg_t msg_in, ev_msg;

  // pack the input fields into one message
  assign msg_in = '{id: message_id_i, prio: message_priority_i,
                    dur: duration_ms_i, cd: cooldown_ms_i};

  pmsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pmsc_dp #(
    .QueueDepth      (QUEUE_DEPTH),
    .CooldownEntries (COOLDOWN_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (command_i),
    .msg_i       (msg_in),
    .elapsed_i   (elapsed_ms_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ev_o        (event_res_o),
    .ev_msg_o    (ev_msg),
    .dropped_o   (dropped_total_o),
    .played_o    (played_total_o),
    .last_o      (last_o)
  );

  // unpack the reported message
  assign event_id_o = ev_msg.id;
  assign event_priority_o = ev_msg.prio;
  assign event_duration_o = ev_msg.dur;
  assign event_cooldown_o = ev_msg.cd;

endmodule
